// File: hw/rtl/sbf_pkg.sv
// ============================================================================
// sbf_pkg
// Shared types and codes for the store buffer with load forwarding.
// ============================================================================
`default_nettype none

package sbf_pkg;

    localparam int ADDR_W = 8;
    localparam int DATA_W = 8;
    localparam int THR_W  = 8;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FENCE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_PENDING = 2'd3;

    // One buffered store as it sits in a cell.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_entry;

    // Per-beat commands broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // Forwarding search result passed from younger to older cells.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } t_search;

endpackage

`default_nettype wire

// File: hw/rtl/sbf_cell.sv
// ============================================================================
// sbf_cell
// One slot of the store queue. Slots are ordered oldest first; a pop shifts
// every slot one place toward the head and a push fills the first free slot.
// ============================================================================
`default_nettype none

module sbf_cell (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire sbf_pkg::t_cell_ctl        i_ctl,
    input  wire [sbf_pkg::ADDR_W-1:0]      i_new_addr,
    input  wire [sbf_pkg::DATA_W-1:0]      i_new_data,
    input  wire                            i_older_valid,
    input  wire sbf_pkg::t_entry           i_younger,
    input  wire [sbf_pkg::ADDR_W-1:0]      i_lookup_addr,
    input  wire sbf_pkg::t_search          i_search,
    output sbf_pkg::t_search               o_search,
    output sbf_pkg::t_entry                o_entry
);

    logic                       r_valid;
    logic [sbf_pkg::ADDR_W-1:0] r_addr;
    logic [sbf_pkg::DATA_W-1:0] r_data;
    logic                       n_valid;
    logic [sbf_pkg::ADDR_W-1:0] n_addr;
    logic [sbf_pkg::DATA_W-1:0] n_data;
    logic                       match;

    always_comb begin
        n_valid = r_valid;
        n_addr  = r_addr;
        n_data  = r_data;
        if (i_ctl.pop) begin
            n_valid = i_younger.valid;
            n_addr  = i_younger.addr;
            n_data  = i_younger.data;
        end else if (i_ctl.push && !r_valid && i_older_valid) begin
            // This is the first free slot behind the youngest store.
            n_valid = 1'b1;
            n_addr  = i_new_addr;
            n_data  = i_new_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_addr <= n_addr;
        r_data <= n_data;
    end

    // A hit from a younger slot takes priority over this one.
    assign match         = r_valid && (r_addr == i_lookup_addr);
    assign o_search.hit  = i_search.hit || match;
    assign o_search.data = i_search.hit ? i_search.data : r_data;

    assign o_entry.valid = r_valid;
    assign o_entry.addr  = r_addr;
    assign o_entry.data  = r_data;

endmodule

`default_nettype wire

// File: hw/rtl/sbf_mem.sv
// ============================================================================
// sbf_mem
// Byte memory behind the store queue, with a registered read port and a
// written flag per word so that never-written words read as zero after reset.
// ============================================================================
`default_nettype none

module sbf_mem #(
    parameter int WORDS  = 256,
    parameter int AW     = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_we,
    input  wire [AW-1:0]                i_waddr,
    input  wire [sbf_pkg::DATA_W-1:0]   i_wdata,
    input  wire [AW-1:0]                i_raddr,
    output logic [sbf_pkg::DATA_W-1:0]  o_rdata
);

    logic [sbf_pkg::DATA_W-1:0] mem [WORDS];
    logic [WORDS-1:0]           r_written;
    logic [sbf_pkg::DATA_W-1:0] r_rdata;
    logic                       r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rvalid  <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_written[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

// File: hw/rtl/tso_store_buffer_with_forwarding_top.sv
// ============================================================================
// tso_store_buffer_with_forwarding_top
// Total-store-order store queue in front of a byte memory with forwarding.
// ============================================================================
// Usage:
//   A request beat is taken on a rising edge with start high and busy low.
//   i_func selects a core write, a drain of the oldest store, a core read or
//   a fence. Every request gives exactly one result beat, shown for one cycle
//   with o_valid high; the receiver cannot stall it.
//   The slot search and the registered memory read fill the first-stage
//   registers at the accepting edge; the result register follows them. A new
//   request may be issued every cycle while busy is low, so the rate is one
//   request per cycle; results come out in request order.
//   The queue is a row of BUF_DEPTH slots kept oldest first. A read compares
//   all slots at once and the youngest matching store wins; otherwise the
//   memory byte is returned. Errors (write while full, drain while empty,
//   fence with stores pending) report a status and change nothing.
//   Reset empties the queue and makes every memory word read as zero; busy
//   stays high for the cycle that follows reset.
// ============================================================================
`default_nettype none

module tso_store_buffer_with_forwarding_top #(
    parameter int BUF_DEPTH = 8,
    parameter int MEM_WORDS = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [sbf_pkg::FUNC_W-1:0]    i_func,
    input  wire [sbf_pkg::ADDR_W-1:0]    i_address,
    input  wire [sbf_pkg::DATA_W-1:0]    i_wr_data,
    input  wire [sbf_pkg::THR_W-1:0]     i_thread,
    output logic                         o_valid,
    output logic [sbf_pkg::FUNC_W-1:0]   o_op_kind,
    output logic [sbf_pkg::ADDR_W-1:0]   o_out_address,
    output logic [sbf_pkg::DATA_W-1:0]   o_out_data,
    output logic [sbf_pkg::THR_W-1:0]    o_out_thread,
    output logic                         o_forwarded,
    output logic [sbf_pkg::STAT_W-1:0]   o_status
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = sbf_pkg::ADDR_W + 8;

    sbf_pkg::t_entry    entry  [BUF_DEPTH];
    sbf_pkg::t_search   search [BUF_DEPTH+1];
    sbf_pkg::t_cell_ctl ctl;

    logic                         accept;
    logic                         empty;
    logic                         full;
    logic [sbf_pkg::ADDR_W-1:0]   eff_addr;
    logic [sbf_pkg::DATA_W-1:0]   mem_rdata;
    logic                         mem_we;

    logic                         r_busy;
    logic                         r_s1_vld;
    logic [sbf_pkg::FUNC_W-1:0]   r_s1_func;
    logic [sbf_pkg::ADDR_W-1:0]   r_s1_addr;
    logic [sbf_pkg::DATA_W-1:0]   r_s1_data;
    logic [sbf_pkg::THR_W-1:0]    r_s1_thread;
    logic                         r_s1_fwd;
    logic [sbf_pkg::STAT_W-1:0]   r_s1_status;
    logic [sbf_pkg::ADDR_W-1:0]   n_s1_addr;
    logic [sbf_pkg::DATA_W-1:0]   n_s1_data;
    logic                         n_s1_fwd;
    logic [sbf_pkg::STAT_W-1:0]   n_s1_status;

    // Address reduced into the memory range by restoring subtraction.
    always_comb begin
        logic [RW-1:0] rem;
        logic [RW-1:0] step;
        rem = {{(RW-sbf_pkg::ADDR_W){1'b0}}, i_address};
        for (int s = 7; s >= 0; s--) begin
            step = RW'(MEM_WORDS) << s;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        eff_addr = rem[sbf_pkg::ADDR_W-1:0];
    end

    assign accept = start && !busy;
    assign empty  = !entry[0].valid;
    assign full   = entry[BUF_DEPTH-1].valid;

    assign ctl.push = accept && (i_func == sbf_pkg::FUNC_WRITE) && !full;
    assign ctl.pop  = accept && (i_func == sbf_pkg::FUNC_DRAIN) && !empty;
    assign mem_we   = ctl.pop;

    assign search[BUF_DEPTH].hit  = 1'b0;
    assign search[BUF_DEPTH].data = '0;

    for (genvar g = 0; g < BUF_DEPTH; g++) begin : g_cell
        sbf_pkg::t_entry younger;
        logic            older_valid;
        if (g == BUF_DEPTH - 1) begin : g_last
            assign younger = '0;
        end else begin : g_mid
            assign younger = entry[g+1];
        end
        if (g == 0) begin : g_head
            assign older_valid = 1'b1;
        end else begin : g_body
            assign older_valid = entry[g-1].valid;
        end

        sbf_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new_addr    (eff_addr),
            .i_new_data    (i_wr_data),
            .i_older_valid (older_valid),
            .i_younger     (younger),
            .i_lookup_addr (eff_addr),
            .i_search      (search[g+1]),
            .o_search      (search[g]),
            .o_entry       (entry[g])
        );
    end

    sbf_mem #(
        .WORDS (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (entry[0].addr[AW-1:0]),
        .i_wdata (entry[0].data),
        .i_raddr (eff_addr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_s1_addr   = '0;
        n_s1_data   = '0;
        n_s1_fwd    = 1'b0;
        n_s1_status = sbf_pkg::STAT_OK;
        case (i_func)
            sbf_pkg::FUNC_WRITE: begin
                n_s1_addr = eff_addr;
                n_s1_data = i_wr_data;
                if (full) begin
                    n_s1_status = sbf_pkg::STAT_FULL;
                end
            end
            sbf_pkg::FUNC_DRAIN: begin
                if (empty) begin
                    n_s1_status = sbf_pkg::STAT_EMPTY;
                end else begin
                    n_s1_addr = entry[0].addr;
                    n_s1_data = entry[0].data;
                end
            end
            sbf_pkg::FUNC_READ: begin
                n_s1_addr = eff_addr;
                n_s1_data = search[0].data;
                n_s1_fwd  = search[0].hit;
            end
            sbf_pkg::FUNC_FENCE: begin
                if (!empty) begin
                    n_s1_status = sbf_pkg::STAT_PENDING;
                end
            end
            default: begin
                n_s1_status = sbf_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_s1_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_s1_vld <= accept;
            o_valid  <= r_s1_vld;
        end
        if (accept) begin
            r_s1_func   <= i_func;
            r_s1_addr   <= n_s1_addr;
            r_s1_data   <= n_s1_data;
            r_s1_thread <= i_thread;
            r_s1_fwd    <= n_s1_fwd;
            r_s1_status <= n_s1_status;
        end
        // The memory byte arrives with the first stage; a buffer hit overrides it.
        o_op_kind     <= r_s1_func;
        o_out_address <= r_s1_addr;
        o_out_data    <= ((r_s1_func == sbf_pkg::FUNC_READ) && !r_s1_fwd) ? mem_rdata
                                                                          : r_s1_data;
        o_out_thread  <= r_s1_thread;
        o_forwarded   <= r_s1_fwd;
        o_status      <= r_s1_status;
    end

    assign busy = r_busy;

endmodule

`default_nettype wire

// File: tb/tso_store_buffer_with_forwarding_top_tb.sv
// ============================================================================
// tso_store_buffer_with_forwarding_top_tb
// Self-checking bench for the store queue with load forwarding: a directed
// table walks the corner cases, then random command beats with random gaps
// are checked against a behavioral model of the queue and the byte memory.
// ============================================================================

module tso_store_buffer_with_forwarding_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH   = 8;
    localparam int MEM_WORDS   = 256;
    localparam int RAND_ITEMS  = 700;
    localparam int BLOCK_ITEMS = 50;
    localparam int TAIL_CYCLES = 8;

    localparam int FUNC_W = sbf_pkg::FUNC_W;
    localparam int ADDR_W = sbf_pkg::ADDR_W;
    localparam int DATA_W = sbf_pkg::DATA_W;
    localparam int THR_W  = sbf_pkg::THR_W;
    localparam int STAT_W = sbf_pkg::STAT_W;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = sbf_pkg::FUNC_WRITE;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN = sbf_pkg::FUNC_DRAIN;
    localparam logic [FUNC_W-1:0] FUNC_READ  = sbf_pkg::FUNC_READ;
    localparam logic [FUNC_W-1:0] FUNC_FENCE = sbf_pkg::FUNC_FENCE;

    localparam logic [STAT_W-1:0] STAT_OK      = sbf_pkg::STAT_OK;
    localparam logic [STAT_W-1:0] STAT_FULL    = sbf_pkg::STAT_FULL;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = sbf_pkg::STAT_EMPTY;
    localparam logic [STAT_W-1:0] STAT_PENDING = sbf_pkg::STAT_PENDING;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [THR_W-1:0]  thread;
        logic              fwd;
        logic [STAT_W-1:0] status;
    } t_sb_result;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [THR_W-1:0]  thread;
        logic              typed_valid;
        t_sb_result        typed;
    } t_cmd_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [ADDR_W-1:0]   i_address;
    logic [DATA_W-1:0]   i_wr_data;
    logic [THR_W-1:0]    i_thread;
    logic                o_valid;
    logic [FUNC_W-1:0]   o_op_kind;
    logic [ADDR_W-1:0]   o_out_address;
    logic [DATA_W-1:0]   o_out_data;
    logic [THR_W-1:0]    o_out_thread;
    logic                o_forwarded;
    logic [STAT_W-1:0]   o_status;

    // Hand-written expectation that rides along with the current command beat.
    logic                row_typed_valid;
    t_sb_result          row_typed;

    // Model of the block: byte memory and the store ring.
    logic [DATA_W-1:0]   mem_image [MEM_WORDS];
    logic [ADDR_W-1:0]   sq_addr [BUF_DEPTH];
    logic [DATA_W-1:0]   sq_data [BUF_DEPTH];
    int unsigned         sq_head;
    int unsigned         sq_count;

    t_sb_result          pending_results [$];
    int                  fail_count;
    t_cmd_row            cmd_table [$];

    tso_store_buffer_with_forwarding_top #(
        .BUF_DEPTH (BUF_DEPTH),
        .MEM_WORDS (MEM_WORDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_wr_data     (i_wr_data),
        .i_thread      (i_thread),
        .o_valid       (o_valid),
        .o_op_kind     (o_op_kind),
        .o_out_address (o_out_address),
        .o_out_data    (o_out_data),
        .o_out_thread  (o_out_thread),
        .o_forwarded   (o_forwarded),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sb_result predict_access(input logic [FUNC_W-1:0] func,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [DATA_W-1:0] wdata,
                                                  input logic [THR_W-1:0] thread);
        t_sb_result        r;
        logic [ADDR_W-1:0] eff;
        int unsigned       slot;
        int unsigned       k;
        bit                hit;
        r        = '0;
        r.op     = func;
        r.thread = thread;
        eff      = ADDR_W'(int'(addr) % MEM_WORDS);
        case (func)
            FUNC_WRITE: begin
                r.addr = eff;
                r.data = wdata;
                if (sq_count >= BUF_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    slot          = (sq_head + sq_count) % BUF_DEPTH;
                    sq_addr[slot] = eff;
                    sq_data[slot] = wdata;
                    sq_count++;
                end
            end
            FUNC_DRAIN: begin
                if (sq_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.addr = sq_addr[sq_head];
                    r.data = sq_data[sq_head];
                    mem_image[int'(r.addr) % MEM_WORDS] = r.data;
                    sq_head = (sq_head + 1) % BUF_DEPTH;
                    sq_count--;
                end
            end
            FUNC_READ: begin
                r.addr = eff;
                r.data = mem_image[eff];
                hit    = 1'b0;
                // Walk from the youngest store toward the oldest.
                for (k = sq_count; k > 0 && !hit; k--) begin
                    slot = (sq_head + k - 1) % BUF_DEPTH;
                    if (sq_addr[slot] == eff) begin
                        r.data = sq_data[slot];
                        r.fwd  = 1'b1;
                        hit    = 1'b1;
                    end
                end
            end
            default: begin
                // Fence: only the status depends on the queue.
                if (sq_count != 0) r.status = STAT_PENDING;
            end
        endcase
        return r;
    endfunction

    function automatic t_cmd_row mk_row(input logic [FUNC_W-1:0] func,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] wdata,
                                        input logic [THR_W-1:0] thread,
                                        input logic typed_valid,
                                        input logic [ADDR_W-1:0] e_addr,
                                        input logic [DATA_W-1:0] e_data,
                                        input logic e_fwd,
                                        input logic [STAT_W-1:0] e_status);
        t_cmd_row r;
        r.func         = func;
        r.addr         = addr;
        r.wdata        = wdata;
        r.thread       = thread;
        r.typed_valid  = typed_valid;
        r.typed.op     = func;
        r.typed.addr   = e_addr;
        r.typed.data   = e_data;
        r.typed.thread = thread;
        r.typed.fwd    = e_fwd;
        r.typed.status = e_status;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Drives one command beat at the falling edge and holds it until taken.
    task automatic issue_beat(input t_cmd_row row, input int gap);
        if (gap > 0) begin
            start           = 1'b0;
            row_typed_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           = 1'b1;
        i_func          = row.func;
        i_address       = row.addr;
        i_wr_data       = row.wdata;
        i_thread        = row.thread;
        row_typed_valid = row.typed_valid;
        row_typed       = row.typed;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Result beats are compared before the beat accepted on the same edge is
    // predicted; that beat's result is registered later, so the two never belong together.
    always @(posedge i_clk) begin
        t_sb_result got;
        t_sb_result want;
        t_sb_result pred;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{o_op_kind, o_out_address, o_out_data, o_out_thread,
                        o_forwarded, o_status};
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got 0x%0h", $time, got);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("op_kind", 32'(want.op), 32'(got.op));
                    check_field("out_address", 32'(want.addr), 32'(got.addr));
                    check_field("out_data", 32'(want.data), 32'(got.data));
                    check_field("out_thread", 32'(want.thread), 32'(got.thread));
                    check_field("forwarded", 32'(want.fwd), 32'(got.fwd));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
            if (start && !busy) begin
                pred = predict_access(i_func, i_address, i_wr_data, i_thread);
                pending_results.push_back(row_typed_valid ? row_typed : pred);
            end
        end
    end

    initial begin
        t_cmd_row          row;
        int                mode;
        bit                calm;
        int                pick;
        int                gap;
        logic [FUNC_W-1:0] f;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] pool [8];

        fail_count      = 0;
        start           = 1'b0;
        i_rst_n         = 1'b0;
        i_func          = FUNC_WRITE;
        i_address       = '0;
        i_wr_data       = '0;
        i_thread        = '0;
        row_typed_valid = 1'b0;
        row_typed       = '0;
        for (int i = 0; i < MEM_WORDS; i++) mem_image[i] = '0;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            sq_addr[i] = '0;
            sq_data[i] = '0;
        end
        sq_head  = 0;
        sq_count = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue, memory cleared by reset.
        cmd_table.push_back(mk_row(FUNC_READ,  8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_READ,  8'hFF, 8'hFF, 8'hFF, 1, 8'hFF, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_DRAIN, 8'h3C, 8'h5A, 8'h01, 1, 8'h00, 8'h00, 0, STAT_EMPTY));
        cmd_table.push_back(mk_row(FUNC_FENCE, 8'hC3, 8'hA5, 8'h02, 1, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'hFF, 8'hFF, 8'h80, 1, 8'hFF, 8'hFF, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_FENCE, 8'hFF, 8'h00, 8'h7F, 1, 8'h00, 8'h00, 0,
                                   STAT_PENDING));
        cmd_table.push_back(mk_row(FUNC_READ,  8'hFF, 8'h00, 8'h10, 1, 8'hFF, 8'hFF, 1, STAT_OK));
        // A second store to the same byte; the younger one must be forwarded.
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'hFF, 8'h00, 8'h11, 1, 8'hFF, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_READ,  8'hFF, 8'h00, 8'h12, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'h00, 8'h01, 8'h13, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'h55, 8'hAA, 8'h14, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'hAA, 8'h55, 8'h15, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'h0F, 8'hF0, 8'h16, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'hF0, 8'h0F, 8'h17, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'h80, 8'h7F, 8'h18, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_WRITE, 8'h01, 8'h02, 8'hFE, 1, 8'h01, 8'h02, 0, STAT_FULL));
        cmd_table.push_back(mk_row(FUNC_READ,  8'h00, 8'h00, 8'h20, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_READ,  8'h01, 8'h00, 8'h21, 0, 8'h00, 8'h00, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_DRAIN, 8'h00, 8'h00, 8'h30, 1, 8'hFF, 8'hFF, 0, STAT_OK));
        cmd_table.push_back(mk_row(FUNC_READ,  8'hFF, 8'h00, 8'h31, 0, 8'h00, 8'h00, 0, STAT_OK));
        for (int i = 0; i < 5; i++) begin
            cmd_table.push_back(mk_row(FUNC_DRAIN, 8'h00, 8'h00, 8'(8'h40 + i), 0,
                                       8'h00, 8'h00, 0, STAT_OK));
        end

        foreach (cmd_table[i]) issue_beat(cmd_table[i], (i % 4 == 2) ? 1 : 0);

        // Random blocks, each with its own mix of operations and a small set
        // of hot addresses so that reads often hit buffered stores.
        for (int blk = 0; blk < RAND_ITEMS / BLOCK_ITEMS; blk++) begin
            mode = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < 8; j++) pool[j] = 8'($urandom);
            if ($urandom_range(0, 1) == 1) pool[0] = 8'h00;
            if ($urandom_range(0, 1) == 1) pool[1] = 8'hFF;
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0: f = (pick < 60) ? FUNC_WRITE : (pick < 90) ? FUNC_READ :
                           (pick < 95) ? FUNC_DRAIN : FUNC_FENCE;
                    1: f = (pick < 50) ? FUNC_DRAIN : (pick < 75) ? FUNC_READ :
                           (pick < 90) ? FUNC_WRITE : FUNC_FENCE;
                    2: f = (pick < 35) ? FUNC_WRITE : (pick < 65) ? FUNC_DRAIN :
                           (pick < 95) ? FUNC_READ : FUNC_FENCE;
                    default: f = FUNC_W'($urandom_range(0, 3));
                endcase
                a = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : 8'($urandom);
                row = mk_row(f, a, 8'($urandom), 8'($urandom), 0, 8'h00, 8'h00, 0, STAT_OK);
                pick = $urandom_range(0, 99);
                if (calm || pick < 70) gap = 0;
                else if (pick < 92) gap = $urandom_range(1, 3);
                else gap = $urandom_range(5, 30);
                issue_beat(row, gap);
            end
        end

        start           = 1'b0;
        row_typed_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
